### src/spq_pkg.sv
// Shared types, constants and helpers of the sorted priority queue.
// Depends on nothing; imported by spq_cell and sorted_priority_queue_core.
package spq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int CODE_W      = 16;
    localparam int PRIO_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 5;
    localparam int IN_DATA_W   = CODE_W + PRIO_W;
    localparam int OUT_FIELD_W = CODE_W + PRIO_W + STATUS_W + OUT_COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One stored entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
    } spq_entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic       ins_en;
        logic       rem_en;
        spq_entry_t entry;
    } spq_cmd_t;

    // What a cell hands to its right neighbor
    typedef struct packed {
        spq_entry_t entry;
        logic       higher;   // new entry goes at or before this cell
    } spq_link_t;

    // Count reported in a result, masked to the output field width
    function automatic logic [OUT_COUNT_W-1:0] out_count(input logic [COUNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

### src/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares against a new one,
// and shifts right on insert or left on remove. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_cmd_t   cmd,
    input  logic       occupied,
    input  spq_link_t  left,
    input  spq_entry_t right,
    output spq_link_t  link
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       higher;

    // Empty slots count as larger than any priority
    assign higher = !occupied || (entry_reg.prio > cmd.entry.prio);

    // Compare and shift
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en && higher)
        begin
            entry_next = left.higher ? left.entry : cmd.entry;
        end
        else if (cmd.rem_en)
        begin
            entry_next = right;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.entry  = entry_reg;
    assign link.higher = higher;

endmodule

### src/sorted_priority_queue_core.sv
// Sorted priority queue: a chain of QUEUE_DEPTH compare-and-shift cells.
// An accepted transaction's result is registered and shown in the next cycle.
// Throughput: one insert or remove per cycle while m_tready does not hold the result; each cell does one compare and
// one neighbor shift per transaction, the count register updates alongside.
// Reset: entry count and output valid clear; slot contents stay undefined.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: entry_code[15:0], entry_priority[31:16]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: action[0]
    input  logic [0:0]            s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: out_code[15:0], out_priority[31:16], status[33:32],
    //          entry_count[38:34], zero pad above
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                valid_reg, valid_next;
    spq_entry_t          res_entry_reg, res_entry_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    spq_cmd_t   cmd;
    spq_link_t  link [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occupied;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Command broadcast to the chain
    always_comb
    begin
        cmd.entry.code = s_tdata[CODE_W-1:0];
        cmd.entry.prio = s_tdata[IN_DATA_W-1:CODE_W];
        cmd.ins_en     = accept && (s_tuser[0] == ACT_INSERT) && !is_full;
        cmd.rem_en     = accept && (s_tuser[0] == ACT_REMOVE) && !is_empty;
    end

    // Cell chain
    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            spq_link_t  left_in;
            spq_entry_t right_in;

            assign occupied[k] = (COUNT_W'(k) < count_reg);

            if (k == 0)
            begin : g_head
                assign left_in.entry  = cmd.entry;
                assign left_in.higher = 1'b0;
            end
            else
            begin : g_body
                assign left_in = link[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_in = link[k].entry;
            end
            else
            begin : g_inner
                assign right_in = link[k+1].entry;
            end

            spq_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .occupied (occupied[k]),
                .left     (left_in),
                .right    (right_in),
                .link     (link[k])
            );
        end
    endgenerate

    // Result and count
    always_comb
    begin
        count_next      = count_reg;
        valid_next      = valid_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next     = 1'b1;
            res_entry_next = '0;
            if (s_tuser[0] == ACT_INSERT)
            begin
                if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    res_status_next = ST_DONE;
                    count_next      = count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    res_status_next = ST_DONE;
                    res_entry_next  = link[0].entry;
                    count_next      = count_reg - COUNT_W'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload, count captured as it stands after the transaction
    logic [OUT_COUNT_W-1:0] res_count_reg;

    always_ff @(posedge clk)
    begin
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= out_count(count_next);
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_count_reg, res_status_reg,
                       res_entry_reg.prio, res_entry_reg.code};

`ifndef SYNTH
    // Count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // Front two slots stay in priority order
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= COUNT_W'(2)) |-> (link[0].entry.prio <= link[1].entry.prio))
        else $error("front slots out of order");

    // Refused insert leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser[0] == ACT_INSERT) && is_full) |=> $stable(count_reg))
        else $error("count changed on refused insert");

    // Remove on a non-empty queue drops the count by one
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem_en |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("count not decremented on remove");
`endif

endmodule
